@@ design/htw_pkg.sv @@
// Shared types and codes of the hierarchical timer wheel.
package htw_pkg;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_SET    = 2'd2;
  localparam logic [1:0] ACT_CANCEL = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOFREE = 2'd1;
  localparam logic [1:0] STAT_NOTACT = 2'd2;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  localparam logic [23:0] REM_MAX = 24'hFFFFFF;
  localparam logic [5:0]  MAX_OUT = 6'd32;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APP_RD,
    ST_APP_CHK,
    ST_APP_TL,
    ST_RM_SLOT,
    ST_RM_HEAD,
    ST_RM_WALK,
    ST_RM_FIX,
    ST_RM_POST,
    ST_RF_RD,
    ST_RF_HD,
    ST_RF_END,
    ST_DR_RD,
    ST_DR_HD,
    ST_WK_REC,
    ST_NEXT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MODE_CMD,
    MODE_REFILE,
    MODE_DRAIN
  } mode_t;

endpackage

@@ design/htw_if.sv @@
// Item channels of the hierarchical timer wheel.
interface htw_in_if import htw_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [4:0]  timer_id;
  logic [23:0] delay;
  logic        periodic;

  modport source(output valid, action, timer_id, delay, periodic, input ready);
  modport sink(input valid, action, timer_id, delay, periodic, output ready);
endinterface

interface htw_out_if import htw_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        kind;
  logic [4:0]  timer_handle;
  logic [1:0]  status;
  logic [23:0] remaining;
  logic        last;

  modport source(output valid, kind, timer_handle, status, remaining, last, input ready);
  modport sink(input valid, kind, timer_handle, status, remaining, last, output ready);
endinterface

@@ design/hierarchical_timer_wheel.sv @@
// Top level of the hierarchical timer wheel: sequencer around slot and timer memories.
// One item is in work at a time; the timer record memory, with one write and one read port,
// sets the pace. After reset every one of the 2^(SLOT_BITS+2) slots (256 by default) is
// cleared in a sweep with input ready low; now is cleared and all timers are inactive.
module hierarchical_timer_wheel import htw_pkg::*; #(
  parameter int SLOT_BITS  = 6,
  parameter int NUM_TIMERS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  htw_in_if.sink     in_if,
  htw_out_if.source  out_if
);

  localparam int SAW   = SLOT_BITS + 2;
  localparam int NSLOT = 4 * (1 << SLOT_BITS);
  localparam int IDW   = $clog2(NUM_TIMERS + 1);
  localparam int TAW   = $clog2(NUM_TIMERS);
  localparam logic [IDW-1:0] EMPTY = IDW'(NUM_TIMERS);
  localparam logic [63:0] SPAN = (64'd1 << (4 * SLOT_BITS)) - 64'd1;

  typedef struct packed {
    logic [31:0]    expiry;
    logic [23:0]    interval;
    logic [IDW-1:0] link;
    logic [SAW-1:0] home;
  } trec_t;

  typedef struct packed {
    logic [IDW-1:0] head;
    logic [IDW-1:0] tail;
  } srec_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic [31:0] now_r, now_nxt;
  logic [NUM_TIMERS-1:0] active_r, active_nxt, periodic_r, periodic_nxt;
  logic [SAW-1:0] clr_r, clr_nxt, sa_r, sa_nxt;
  logic [IDW-1:0] cur_r, cur_nxt, nx_r, nx_nxt, prev_r, prev_nxt, id_r, id_nxt;
  logic [IDW-1:0] sh_r, sh_nxt, st_r, st_nxt;
  logic [31:0] ex_r, ex_nxt;
  logic [23:0] ival_r, ival_nxt;
  logic [1:0]  lvl_r, lvl_nxt, op_r, op_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  trec_t rec_r, rec_nxt, prec_r, prec_nxt;
  logic        res_kind_r, res_kind_nxt, res_last_r, res_last_nxt;
  logic [4:0]  res_handle_r, res_handle_nxt;
  logic [1:0]  res_status_r, res_status_nxt;
  logic [23:0] res_rem_r, res_rem_nxt;
  logic        out_valid_r, out_valid_nxt, out_kind_r, out_kind_nxt;
  logic        out_last_r, out_last_nxt;
  logic [4:0]  out_handle_r, out_handle_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [23:0] out_rem_r, out_rem_nxt;

  logic           t_we, s_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [SAW-1:0] s_waddr, s_raddr;
  trec_t          t_wdata, t_rdata;
  srec_t          s_wdata, s_rdata;

  logic [23:0]    delay_c;
  logic [TAW-1:0] free_idx, tid;
  logic           free_ok, id_ok;
  logic [31:0]    diff;
  logic [SAW-1:0] slot_calc;
  logic [23:0]    rem_calc;
  logic [SLOT_BITS-1:0] lvl_digit;
  state_t         after_file;

  htw_ram #(.WIDTH($bits(trec_t)), .DEPTH(NUM_TIMERS)) u_trec (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  htw_ram #(.WIDTH($bits(srec_t)), .DEPTH(NSLOT)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign delay_c = (64'(in_if.delay) > SPAN) ? SPAN[23:0] : in_if.delay;
  assign tid     = TAW'(in_if.timer_id);
  assign id_ok   = (32'(in_if.timer_id) < 32'(NUM_TIMERS)) && active_r[tid];

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_ok  = 1'b1;
        free_idx = TAW'(i);
      end
    end
  end

  // Slot choice from the time left until expiry.
  assign diff = ex_r - now_r;
  always_comb begin
    if (diff[31]) begin
      slot_calc = {2'd0, now_r[SLOT_BITS-1:0]};
    end else if ((diff >> SLOT_BITS) == 32'd0) begin
      slot_calc = {2'd0, ex_r[SLOT_BITS-1:0]};
    end else if ((diff >> (2 * SLOT_BITS)) == 32'd0) begin
      slot_calc = {2'd1, ex_r[SLOT_BITS +: SLOT_BITS]};
    end else if ((diff >> (3 * SLOT_BITS)) == 32'd0) begin
      slot_calc = {2'd2, ex_r[2 * SLOT_BITS +: SLOT_BITS]};
    end else begin
      slot_calc = {2'd3, ex_r[3 * SLOT_BITS +: SLOT_BITS]};
    end
    if (diff[31]) begin
      rem_calc = '0;
    end else if (diff > 32'(REM_MAX)) begin
      rem_calc = REM_MAX;
    end else begin
      rem_calc = diff[23:0];
    end
  end

  always_comb begin
    case (lvl_r)
      2'd1:    lvl_digit = now_r[SLOT_BITS +: SLOT_BITS];
      2'd2:    lvl_digit = now_r[2 * SLOT_BITS +: SLOT_BITS];
      2'd3:    lvl_digit = now_r[3 * SLOT_BITS +: SLOT_BITS];
      default: lvl_digit = now_r[SLOT_BITS-1:0];
    endcase
  end

  always_comb begin
    case (mode_r)
      MODE_REFILE: after_file = ST_NEXT;
      MODE_DRAIN:  after_file = (cnt_r < MAX_OUT) ? ST_EMIT : ST_NEXT;
      default:     after_file = ST_EMIT;
    endcase
  end

  assign in_if.ready         = (state_r == ST_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = out_kind_r;
  assign out_if.timer_handle = out_handle_r;
  assign out_if.status       = out_status_r;
  assign out_if.remaining    = out_rem_r;
  assign out_if.last         = out_last_r;

  always_comb begin
    state_nxt = state_r;      mode_nxt = mode_r;        now_nxt = now_r;
    active_nxt = active_r;    periodic_nxt = periodic_r;
    clr_nxt = clr_r;          sa_nxt = sa_r;            cur_nxt = cur_r;
    nx_nxt = nx_r;            prev_nxt = prev_r;        id_nxt = id_r;
    sh_nxt = sh_r;            st_nxt = st_r;            ex_nxt = ex_r;
    ival_nxt = ival_r;        lvl_nxt = lvl_r;          op_nxt = op_r;
    cnt_nxt = cnt_r;          rec_nxt = rec_r;          prec_nxt = prec_r;
    res_kind_nxt = res_kind_r;     res_last_nxt = res_last_r;
    res_handle_nxt = res_handle_r; res_status_nxt = res_status_r;
    res_rem_nxt = res_rem_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_kind_nxt = out_kind_r;     out_last_nxt = out_last_r;
    out_handle_nxt = out_handle_r; out_status_nxt = out_status_r;
    out_rem_nxt = out_rem_r;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;

    case (state_r)
      ST_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_r;
        s_wdata = '{head: EMPTY, tail: EMPTY};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_if.valid) begin
          mode_nxt     = MODE_CMD;
          res_kind_nxt = KIND_REPLY;
          res_last_nxt = 1'b1;
          op_nxt       = in_if.action;
          id_nxt       = IDW'(in_if.timer_id);
          ex_nxt       = now_r + 32'(delay_c);
          case (in_if.action)
            ACT_TICK: begin
              if (now_r[SLOT_BITS-1:0] == '0) begin
                lvl_nxt   = 2'd1;
                state_nxt = ST_RF_RD;
              end else begin
                state_nxt = ST_DR_RD;
              end
            end
            ACT_START: begin
              if (!free_ok) begin
                res_handle_nxt = '0;
                res_status_nxt = STAT_NOFREE;
                res_rem_nxt    = '0;
                state_nxt      = ST_EMIT;
              end else begin
                active_nxt[free_idx]   = 1'b1;
                periodic_nxt[free_idx] = in_if.periodic;
                cur_nxt        = IDW'(free_idx);
                ival_nxt       = delay_c;
                res_handle_nxt = 5'(free_idx);
                res_status_nxt = STAT_OK;
                res_rem_nxt    = delay_c;
                state_nxt      = ST_APP_RD;
              end
            end
            default: begin
              res_handle_nxt = in_if.timer_id;
              if (!id_ok) begin
                res_status_nxt = STAT_NOTACT;
                res_rem_nxt    = '0;
                state_nxt      = ST_EMIT;
              end else begin
                res_status_nxt = STAT_OK;
                res_rem_nxt    = (in_if.action == ACT_SET) ? delay_c : 24'd0;
                t_raddr        = tid;
                state_nxt      = ST_RM_SLOT;
              end
            end
          endcase
        end
      end
      ST_RM_SLOT: begin
        rec_nxt   = t_rdata;
        s_raddr   = t_rdata.home;
        state_nxt = ST_RM_HEAD;
      end
      ST_RM_HEAD: begin
        sh_nxt   = s_rdata.head;
        st_nxt   = s_rdata.tail;
        prev_nxt = EMPTY;
        if (s_rdata.head == id_r) begin
          state_nxt = ST_RM_FIX;
        end else if (s_rdata.head >= EMPTY) begin
          state_nxt = ST_RM_POST;
        end else begin
          cur_nxt   = s_rdata.head;
          t_raddr   = s_rdata.head[TAW-1:0];
          state_nxt = ST_RM_WALK;
        end
      end
      ST_RM_WALK: begin
        prec_nxt = t_rdata;
        prev_nxt = cur_r;
        cur_nxt  = t_rdata.link;
        if (t_rdata.link == id_r) begin
          state_nxt = ST_RM_FIX;
        end else if (t_rdata.link >= EMPTY) begin
          state_nxt = ST_RM_POST;
        end else begin
          t_raddr = t_rdata.link[TAW-1:0];
        end
      end
      ST_RM_FIX: begin
        s_we         = 1'b1;
        s_waddr      = rec_r.home;
        s_wdata.tail = (st_r == id_r) ? prev_r : st_r;
        if (prev_r == EMPTY) begin
          s_wdata.head = rec_r.link;
        end else begin
          s_wdata.head = sh_r;
          t_we         = 1'b1;
          t_waddr      = prev_r[TAW-1:0];
          t_wdata      = prec_r;
          t_wdata.link = rec_r.link;
        end
        state_nxt = ST_RM_POST;
      end
      ST_RM_POST: begin
        if (op_r == ACT_SET) begin
          cur_nxt   = id_r;
          ival_nxt  = rec_r.interval;
          state_nxt = ST_APP_RD;
        end else begin
          active_nxt[id_r[TAW-1:0]]   = 1'b0;
          periodic_nxt[id_r[TAW-1:0]] = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_APP_RD: begin
        sa_nxt  = slot_calc;
        s_raddr = slot_calc;
        if (mode_r == MODE_DRAIN) begin
          res_rem_nxt = rem_calc;
        end
        state_nxt = ST_APP_CHK;
      end
      ST_APP_CHK: begin
        t_we    = 1'b1;
        t_waddr = cur_r[TAW-1:0];
        t_wdata = '{expiry: ex_r, interval: ival_r, link: EMPTY, home: sa_r};
        s_we    = 1'b1;
        s_waddr = sa_r;
        if (s_rdata.head == EMPTY) begin
          s_wdata   = '{head: cur_r, tail: cur_r};
          state_nxt = after_file;
        end else begin
          s_wdata   = '{head: s_rdata.head, tail: cur_r};
          prev_nxt  = s_rdata.tail;
          t_raddr   = s_rdata.tail[TAW-1:0];
          state_nxt = ST_APP_TL;
        end
      end
      ST_APP_TL: begin
        t_we         = 1'b1;
        t_waddr      = prev_r[TAW-1:0];
        t_wdata      = t_rdata;
        t_wdata.link = cur_r;
        state_nxt    = after_file;
      end
      ST_RF_RD: begin
        sa_nxt    = {lvl_r, lvl_digit};
        s_raddr   = {lvl_r, lvl_digit};
        mode_nxt  = MODE_REFILE;
        state_nxt = ST_RF_HD;
      end
      ST_RF_HD: begin
        s_we    = 1'b1;
        s_waddr = sa_r;
        s_wdata = '{head: EMPTY, tail: EMPTY};
        if (s_rdata.head == EMPTY) begin
          state_nxt = ST_RF_END;
        end else begin
          cur_nxt   = s_rdata.head;
          t_raddr   = s_rdata.head[TAW-1:0];
          state_nxt = ST_WK_REC;
        end
      end
      ST_RF_END: begin
        if (lvl_digit == '0 && lvl_r != 2'd3) begin
          lvl_nxt   = lvl_r + 2'd1;
          state_nxt = ST_RF_RD;
        end else begin
          state_nxt = ST_DR_RD;
        end
      end
      ST_DR_RD: begin
        sa_nxt    = {2'd0, now_r[SLOT_BITS-1:0]};
        s_raddr   = {2'd0, now_r[SLOT_BITS-1:0]};
        now_nxt   = now_r + 32'd1;
        mode_nxt  = MODE_DRAIN;
        cnt_nxt   = '0;
        state_nxt = ST_DR_HD;
      end
      ST_DR_HD: begin
        s_we    = 1'b1;
        s_waddr = sa_r;
        s_wdata = '{head: EMPTY, tail: EMPTY};
        if (s_rdata.head == EMPTY) begin
          state_nxt = ST_IDLE;
        end else begin
          cur_nxt   = s_rdata.head;
          t_raddr   = s_rdata.head[TAW-1:0];
          state_nxt = ST_WK_REC;
        end
      end
      ST_WK_REC: begin
        rec_nxt = t_rdata;
        nx_nxt  = t_rdata.link;
        if (mode_r == MODE_REFILE) begin
          ex_nxt    = t_rdata.expiry;
          ival_nxt  = t_rdata.interval;
          state_nxt = ST_APP_RD;
        end else begin
          res_kind_nxt   = KIND_EXPIRY;
          res_handle_nxt = 5'(cur_r);
          res_status_nxt = STAT_OK;
          res_last_nxt   = (t_rdata.link >= EMPTY) || (cnt_r == MAX_OUT - 6'd1);
          if (periodic_r[cur_r[TAW-1:0]]) begin
            ex_nxt    = t_rdata.expiry + 32'(t_rdata.interval);
            ival_nxt  = t_rdata.interval;
            state_nxt = ST_APP_RD;
          end else begin
            active_nxt[cur_r[TAW-1:0]] = 1'b0;
            res_rem_nxt = '0;
            state_nxt   = (cnt_r < MAX_OUT) ? ST_EMIT : ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        if (nx_r >= EMPTY) begin
          state_nxt = (mode_r == MODE_REFILE) ? ST_RF_END : ST_IDLE;
        end else begin
          cur_nxt   = nx_r;
          t_raddr   = nx_r[TAW-1:0];
          state_nxt = ST_WK_REC;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = res_kind_r;
          out_handle_nxt = res_handle_r;
          out_status_nxt = res_status_r;
          out_rem_nxt    = res_rem_r;
          out_last_nxt   = res_last_r;
          if (mode_r == MODE_DRAIN) begin
            cnt_nxt   = cnt_r + 6'd1;
            state_nxt = ST_NEXT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      now_r       <= '0;
      active_r    <= '0;
      periodic_r  <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_CMD;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      now_r       <= now_nxt;
      active_r    <= active_nxt;
      periodic_r  <= periodic_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sa_r <= sa_nxt;     cur_r <= cur_nxt;   nx_r <= nx_nxt;
    prev_r <= prev_nxt; id_r <= id_nxt;     sh_r <= sh_nxt;
    st_r <= st_nxt;     ex_r <= ex_nxt;     ival_r <= ival_nxt;
    lvl_r <= lvl_nxt;   op_r <= op_nxt;     rec_r <= rec_nxt;
    prec_r <= prec_nxt;
    res_kind_r <= res_kind_nxt;     res_last_r <= res_last_nxt;
    res_handle_r <= res_handle_nxt; res_status_r <= res_status_nxt;
    res_rem_r <= res_rem_nxt;
    out_kind_r <= out_kind_nxt;     out_last_r <= out_last_nxt;
    out_handle_r <= out_handle_nxt; out_status_r <= out_status_nxt;
    out_rem_r <= out_rem_nxt;
  end

`ifndef SYNTHESIS
  a_periodic_active: assert property (@(posedge clk) disable iff (!rst_n)
    (periodic_r & ~active_r) == '0)
    else $error("Periodic flag set on an inactive timer.");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_OUT)
    else $error("Notice count passed its limit.");

  a_now_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && now_r != $past(now_r)) |-> now_r == $past(now_r) + 32'd1)
    else $error("Time moved by more than one tick.");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("Output item raised outside the emit step.");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !out_valid_r && !in_if.ready)
    else $error("Traffic during the slot clearing sweep.");
`endif

endmodule

@@ design/htw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ dv/htw_checker.sv @@
// Timer wheel scoreboard: mirrors the wheel state and checks every result item in order.
module htw_checker import htw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  htw_in_if    in_ch,
  htw_out_if   out_ch,
  output int   pending,
  output int   errors,
  output int   notices
);

  typedef struct packed {
    logic        kind;
    logic [4:0]  handle;
    logic [1:0]  status;
    logic [23:0] remaining;
    logic        last;
  } result_t;

  localparam logic [5:0] NIL = 6'd32;

  result_t     due_q[$];
  logic [31:0] now_t;
  logic [31:0] expiry[32];
  logic [23:0] interval[32];
  bit          active[32];
  bit          repeats[32];
  logic [5:0]  head[256];
  logic [5:0]  tail[256];
  logic [5:0]  link[32];
  logic [7:0]  home[32];

  function automatic void append(logic [7:0] s, logic [4:0] id);
    link[id] = NIL;
    if (head[s] == NIL) head[s] = {1'b0, id};
    else link[tail[s][4:0]] = {1'b0, id};
    tail[s] = {1'b0, id};
    home[id] = s;
  endfunction

  function automatic void unlink(logic [4:0] id);
    logic [7:0] s;
    logic [5:0] prev;
    logic [5:0] cur;
    int guard;
    s = home[id];
    prev = NIL;
    cur = head[s];
    guard = 0;
    while (cur < NIL && cur != {1'b0, id} && guard < 32) begin
      prev = cur;
      cur = link[cur[4:0]];
      guard++;
    end
    if (cur != {1'b0, id}) return;
    if (prev == NIL) head[s] = link[id];
    else link[prev[4:0]] = link[id];
    if (tail[s] == {1'b0, id}) tail[s] = prev;
  endfunction

  function automatic void place(logic [4:0] id);
    logic [31:0] ex;
    logic [31:0] diff;
    logic [7:0] s;
    ex = expiry[id];
    diff = ex - now_t;
    if (diff[31]) s = {2'd0, now_t[5:0]};
    else if (diff < 32'd64) s = {2'd0, ex[5:0]};
    else if (diff < 32'd4096) s = {2'd1, ex[11:6]};
    else if (diff < 32'd262144) s = {2'd2, ex[17:12]};
    else s = {2'd3, ex[23:18]};
    append(s, id);
  endfunction

  function automatic void cascade(logic [1:0] level, logic [5:0] idx);
    logic [7:0] s;
    logic [5:0] cur;
    logic [5:0] nx;
    s = {level, idx};
    cur = head[s];
    head[s] = NIL;
    tail[s] = NIL;
    while (cur < NIL) begin
      nx = link[cur[4:0]];
      place(cur[4:0]);
      cur = nx;
    end
  endfunction

  function automatic void predict_tick();
    logic [31:0] t;
    logic [5:0] cur;
    logic [5:0] nx;
    logic [31:0] diff;
    logic [23:0] rem;
    int n;
    result_t r;
    t = now_t;
    n = 0;
    if (t[5:0] == 6'd0) begin
      cascade(2'd1, t[11:6]);
      if (t[11:6] == 6'd0) begin
        cascade(2'd2, t[17:12]);
        if (t[17:12] == 6'd0) cascade(2'd3, t[23:18]);
      end
    end
    now_t = t + 32'd1;
    cur = head[{2'd0, t[5:0]}];
    head[{2'd0, t[5:0]}] = NIL;
    tail[{2'd0, t[5:0]}] = NIL;
    while (cur < NIL) begin
      nx = link[cur[4:0]];
      rem = '0;
      if (repeats[cur[4:0]]) begin
        expiry[cur[4:0]] = expiry[cur[4:0]] + {8'd0, interval[cur[4:0]]};
        place(cur[4:0]);
        diff = expiry[cur[4:0]] - now_t;
        if (!diff[31]) rem = (diff > {8'd0, REM_MAX}) ? REM_MAX : diff[23:0];
      end else begin
        active[cur[4:0]] = 0;
      end
      if (n < 32) begin
        r = '{KIND_EXPIRY, cur[4:0], STAT_OK, rem, 1'b0};
        due_q.push_back(r);
        n++;
      end
      cur = nx;
    end
    if (n > 0) due_q[$].last = 1'b1;
  endfunction

  function automatic void predict(logic [1:0] act, logic [4:0] id, logic [23:0] dly,
                                  logic per);
    int i;
    result_t r;
    case (act)
      ACT_TICK: begin
        predict_tick();
      end
      ACT_START: begin
        i = 0;
        while (i < 32 && active[i]) i++;
        if (i >= 32) begin
          r = '{KIND_REPLY, 5'd0, STAT_NOFREE, 24'd0, 1'b1};
        end else begin
          active[i] = 1;
          repeats[i] = per;
          interval[i] = dly;
          expiry[i] = now_t + {8'd0, dly};
          place(i[4:0]);
          r = '{KIND_REPLY, i[4:0], STAT_OK, dly, 1'b1};
        end
        due_q.push_back(r);
      end
      default: begin
        if (!active[id]) begin
          r = '{KIND_REPLY, id, STAT_NOTACT, 24'd0, 1'b1};
        end else if (act == ACT_SET) begin
          unlink(id);
          expiry[id] = now_t + {8'd0, dly};
          place(id);
          r = '{KIND_REPLY, id, STAT_OK, dly, 1'b1};
        end else begin
          unlink(id);
          active[id] = 0;
          r = '{KIND_REPLY, id, STAT_OK, 24'd0, 1'b1};
        end
        due_q.push_back(r);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      now_t = '0;
      for (int i = 0; i < 32; i++) begin
        active[i] = 0;
        repeats[i] = 0;
        link[i] = '0;
        home[i] = '0;
        expiry[i] = '0;
        interval[i] = '0;
      end
      for (int i = 0; i < 256; i++) begin
        head[i] = NIL;
        tail[i] = NIL;
      end
      due_q.delete();
      pending <= 0;
      errors <= 0;
      notices <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.timer_handle, out_ch.status, out_ch.remaining,
                out_ch.last};
        if (got.kind == KIND_EXPIRY) notices <= notices + 1;
        if (due_q.size() == 0) begin
          if (errors < 10) $display("unexpected result item: %p", got);
          errors <= errors + 1;
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("mismatch: expected %p, got %p", want, got);
            errors <= errors + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict(in_ch.action, in_ch.timer_id, in_ch.delay, in_ch.periodic);
      pending <= due_q.size();
    end
  end

endmodule

@@ dv/testbench.sv @@
// Top of the timer wheel testbench: clock, reset, stimulus, stall control and verdict.
module testbench;
  import htw_pkg::*;

  logic clk;
  logic rst_n;
  int   pending;
  int   errors;
  int   notices;
  int   snd_idle;
  int   rcv_idle;
  int   quiet;
  int   sent;

  htw_in_if  in_if();
  htw_out_if out_if();

  hierarchical_timer_wheel uut (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if));

  htw_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .pending(pending), .errors(errors), .notices(notices)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 30000) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send(logic [1:0] act, logic [4:0] id, logic [23:0] dly, logic per);
    while ($urandom_range(99) < snd_idle) begin
      in_if.valid <= 0;
      @(posedge clk);
    end
    in_if.valid <= 1;
    in_if.action <= act;
    in_if.timer_id <= id;
    in_if.delay <= dly;
    in_if.periodic <= per;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  task automatic send_random();
    int pick;
    logic [23:0] dly;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0: dly = 24'($urandom());
      1: dly = 24'($urandom_range(5000));
      2: dly = REM_MAX;
      default: dly = 24'($urandom_range(70));
    endcase
    if (pick < 45) send(ACT_TICK, 5'($urandom()), 24'($urandom()), 1'($urandom()));
    else if (pick < 72) send(ACT_START, 5'($urandom()), dly, 1'($urandom()));
    else if (pick < 86) send(ACT_SET, 5'($urandom()), dly, 1'($urandom()));
    else send(ACT_CANCEL, 5'($urandom()), 24'($urandom()), 1'($urandom()));
  endtask

  initial begin
    in_if.valid = 0;
    in_if.action = ACT_TICK;
    in_if.timer_id = '0;
    in_if.delay = '0;
    in_if.periodic = 0;
    rst_n = 0;
    snd_idle = 29;
    rcv_idle = 65;
    sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(ACT_START, 5'd0, 24'd0, 1'b0);
    send(ACT_START, 5'd0, 24'd0, 1'b1);
    send(ACT_START, 5'd31, REM_MAX, 1'b0);
    send(ACT_START, 5'd0, 24'd3, 1'b1);
    send(ACT_START, 5'd0, 24'd100, 1'b1);
    send(ACT_SET, 5'd31, 24'd5, 1'b0);
    send(ACT_CANCEL, 5'd30, 24'd0, 1'b0);
    send(ACT_TICK, 5'd0, 24'd0, 1'b0);
    send(ACT_TICK, 5'd31, REM_MAX, 1'b1);
    send(ACT_SET, 5'd2, 24'd1, 1'b1);
    send(ACT_CANCEL, 5'd3, REM_MAX, 1'b1);
    send(ACT_CANCEL, 5'd3, 24'd0, 1'b0);
    send(ACT_SET, 5'd4, 24'd64, 1'b0);
    repeat (6) send(ACT_TICK, 5'd0, 24'd0, 1'b0);
    in_if.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) begin
      repeat (70) send_random();
      if (snd_idle == 29) begin
        snd_idle = 65;
        rcv_idle = 29;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
    end
    repeat (40) send(ACT_TICK, 5'd0, 24'd0, 1'b0);
    in_if.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Covered %0d items: starts, re-arms, set-expiry, cancels and %0d expiry notices,",
             sent, notices);
    $display("across three sender and receiver stall patterns.");
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
